/* src/pmfi_pkg.sv */
package pmfi_pkg;

   // Default geometry of the state words
   localparam int DEFAULT_WORD_WIDTH = 32;
   localparam int DEFAULT_FRAC_BITS  = 16;

   // Fraction bits of the thrust command, buoyancy fraction and step duration
   localparam int IN_FRAC = 16;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 31;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MASS           = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DRAG_COEFF     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_THRUST_MAX     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BUOYANCY_FRAC  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPEED_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLIMB_LIMIT    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DESCENT_LIMIT  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_ALTITUDE = 3'd7;

   // Register reset values
   localparam logic [30:0] MASS_RESET           = 31'd65536;
   localparam logic [30:0] DRAG_COEFF_RESET     = 31'd0;
   localparam logic [30:0] THRUST_MAX_RESET     = 31'd0;
   localparam logic [16:0] BUOYANCY_FRAC_RESET  = 17'd0;
   localparam logic [30:0] SPEED_LIMIT_RESET    = 31'd655360;
   localparam logic [30:0] CLIMB_LIMIT_RESET    = 31'd655360;
   localparam logic [30:0] DESCENT_LIMIT_RESET  = 31'd655360;
   localparam logic [30:0] START_ALTITUDE_RESET = 31'd0;

   // Arithmetic unit operations
   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

endpackage

/* src/point_mass_flight_integrator.sv */
// Point-mass flight integrator in signed fixed point (WORD_WIDTH bits, FRAC_BITS fraction).
// A transaction is a time step or, with mode set, a restart; each gives one result holding
// the new NED velocity and position and the two limit flags. Every multiply, divide and
// square root runs through one iterative unit: a shift-add multiplier over
// MB = max(WORD_WIDTH,31) multiplier bits, a restoring divider giving
// XW = max(2*MB, WORD_WIDTH+32) quotient bits and a square root giving
// WORD_WIDTH root bits. The block accepts one transaction at a time; a finished
// result waits in its output register while the next transaction is accepted.
module point_mass_flight_integrator #(
   parameter int WORD_WIDTH = pmfi_pkg::DEFAULT_WORD_WIDTH,
   parameter int FRAC_BITS  = pmfi_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [pmfi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pmfi_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [16:0]                          req_thrust_cmd,
   input  logic [15:0]                          req_time_step,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_vel_n_out,
   output logic signed [31:0]                   rsp_vel_e_out,
   output logic signed [31:0]                   rsp_vel_d_out,
   output logic signed [31:0]                   rsp_pos_n_out,
   output logic signed [31:0]                   rsp_pos_e_out,
   output logic signed [31:0]                   rsp_pos_d_out,
   output logic                                 rsp_horiz_limited,
   output logic                                 rsp_vert_clamped
);

   localparam int W  = WORD_WIDTH;
   localparam int MB = (W > 31) ? W : 31;
   localparam int XW = (2 * MB > W + 32) ? 2 * MB : W + 32;
   localparam int EW = (W > 32) ? W : 32;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [XW-1:0] LIM_POS = XW'(WMAX);
   localparam logic [XW-1:0] LIM_NEG = XW'(WMAX) + XW'(1);
   localparam logic [XW-1:0] GRAV =
      XW'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);

   // Sequencer states
   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DRAG_N  = 5'd1;
   localparam logic [4:0] S_DRAG_E  = 5'd2;
   localparam logic [4:0] S_DRAG_D  = 5'd3;
   localparam logic [4:0] S_THRUST  = 5'd4;
   localparam logic [4:0] S_WEIGHT  = 5'd5;
   localparam logic [4:0] S_BUOY    = 5'd6;
   localparam logic [4:0] S_ACC_N   = 5'd7;
   localparam logic [4:0] S_DT_N    = 5'd8;
   localparam logic [4:0] S_ACC_E   = 5'd9;
   localparam logic [4:0] S_DT_E    = 5'd10;
   localparam logic [4:0] S_ACC_D   = 5'd11;
   localparam logic [4:0] S_DT_D    = 5'd12;
   localparam logic [4:0] S_SQ_N    = 5'd13;
   localparam logic [4:0] S_SQ_E    = 5'd14;
   localparam logic [4:0] S_SQ_LIM  = 5'd15;
   localparam logic [4:0] S_SQRT    = 5'd16;
   localparam logic [4:0] S_SCN_MUL = 5'd17;
   localparam logic [4:0] S_SCN_DIV = 5'd18;
   localparam logic [4:0] S_SCE_MUL = 5'd19;
   localparam logic [4:0] S_SCE_DIV = 5'd20;
   localparam logic [4:0] S_CLAMP   = 5'd21;
   localparam logic [4:0] S_POS_N   = 5'd22;
   localparam logic [4:0] S_POS_E   = 5'd23;
   localparam logic [4:0] S_POS_D   = 5'd24;
   localparam logic [4:0] S_DONE    = 5'd25;

   // Saturating helpers
   function automatic logic [XW-1:0] mag(input logic signed [W-1:0] a);
      logic signed [XW-1:0] t;
      t = XW'(a);
      return a[W-1] ? XW'(-t) : XW'(t);
   endfunction

   function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic [XW-1:0] m);
      logic [XW-1:0] lim;
      logic [XW-1:0] v;
      lim = neg ? LIM_NEG : LIM_POS;
      v   = (m > lim) ? lim : m;
      return neg ? -W'(v) : W'(v);
   endfunction

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = (W+1)'(a) + (W+1)'(b);
      if (s[W] != s[W-1]) begin
         return s[W] ? WMIN : WMAX;
      end
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] a);
      return (a == WMIN) ? WMAX : -a;
   endfunction

   function automatic logic signed [W-1:0] clampw(input logic [30:0] v);
      return (XW'(v) > LIM_POS) ? WMAX : W'(v);
   endfunction

   function automatic logic [31:0] low32(input logic signed [W-1:0] a);
      logic signed [EW-1:0] t;
      t = EW'(a);
      return t[31:0];
   endfunction

   // Configuration registers
   logic [30:0] mass_ff, drag_ff, tmax_ff, speed_ff, climb_ff, descent_ff, alt_ff;
   logic [16:0] buoyf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff    <= pmfi_pkg::MASS_RESET;
         drag_ff    <= pmfi_pkg::DRAG_COEFF_RESET;
         tmax_ff    <= pmfi_pkg::THRUST_MAX_RESET;
         buoyf_ff   <= pmfi_pkg::BUOYANCY_FRAC_RESET;
         speed_ff   <= pmfi_pkg::SPEED_LIMIT_RESET;
         climb_ff   <= pmfi_pkg::CLIMB_LIMIT_RESET;
         descent_ff <= pmfi_pkg::DESCENT_LIMIT_RESET;
         alt_ff     <= pmfi_pkg::START_ALTITUDE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pmfi_pkg::REG_MASS:           mass_ff    <= csr_wdata;
            pmfi_pkg::REG_DRAG_COEFF:     drag_ff    <= csr_wdata;
            pmfi_pkg::REG_THRUST_MAX:     tmax_ff    <= csr_wdata;
            pmfi_pkg::REG_BUOYANCY_FRAC:  buoyf_ff   <= csr_wdata[16:0];
            pmfi_pkg::REG_SPEED_LIMIT:    speed_ff   <= csr_wdata;
            pmfi_pkg::REG_CLIMB_LIMIT:    climb_ff   <= csr_wdata;
            pmfi_pkg::REG_DESCENT_LIMIT:  descent_ff <= csr_wdata;
            pmfi_pkg::REG_START_ALTITUDE: alt_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sequencer and state
   logic [4:0]          st_ff, st_in;
   logic                issued_ff, issued_in;
   logic signed [W-1:0] vn_ff, vn_in, ve_ff, ve_in, vd_ff, vd_in;
   logic signed [W-1:0] pn_ff, pn_in, pe_ff, pe_in, pd_ff, pd_in;
   logic signed [W-1:0] dn_ff, dn_in, de_ff, de_in, fz_ff, fz_in;
   logic signed [W-1:0] thr_ff, thr_in, wgt_ff, wgt_in, tmp_ff, tmp_in;
   logic [XW-1:0]       sq_ff, sq_in;
   logic [W-1:0]        hs_ff, hs_in;
   logic                hflag_ff, hflag_in, vflag_ff, vflag_in;
   logic [16:0]         cmd_ff, cmd_in;
   logic [15:0]         dt_ff, dt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         o_vn_ff, o_vn_in, o_ve_ff, o_ve_in, o_vd_ff, o_vd_in;
   logic [31:0]         o_pn_ff, o_pn_in, o_pe_ff, o_pe_in, o_pd_ff, o_pd_in;
   logic                o_h_ff, o_h_in, o_v_ff, o_v_in;

   pmfi_pkg::alu_cmd_type  alu_cmd;
   pmfi_pkg::alu_stat_type alu_stat;
   logic [XW-1:0]          alu_a, alu_b, alu_res;

   logic [30:0]         m_eff;
   logic signed [W-1:0] buoy_val, lo_v, hi_v;

   assign m_eff     = (mass_ff == '0) ? 31'd1 : mass_ff;
   assign req_ready = (st_ff == S_IDLE);
   assign buoy_val  = sat_mag(1'b0, alu_res >> pmfi_pkg::IN_FRAC);
   assign lo_v      = sat_neg(clampw(climb_ff));
   assign hi_v      = clampw(descent_ff);

   always_comb begin
      st_in        = st_ff;
      issued_in    = issued_ff;
      vn_in = vn_ff; ve_in = ve_ff; vd_in = vd_ff;
      pn_in = pn_ff; pe_in = pe_ff; pd_in = pd_ff;
      dn_in = dn_ff; de_in = de_ff; fz_in = fz_ff;
      thr_in = thr_ff; wgt_in = wgt_ff; tmp_in = tmp_ff;
      sq_in = sq_ff; hs_in = hs_ff;
      hflag_in = hflag_ff; vflag_in = vflag_ff;
      cmd_in = cmd_ff; dt_in = dt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      o_vn_in = o_vn_ff; o_ve_in = o_ve_ff; o_vd_in = o_vd_ff;
      o_pn_in = o_pn_ff; o_pe_in = o_pe_ff; o_pd_in = o_pd_ff;
      o_h_in = o_h_ff; o_v_in = o_v_ff;
      alu_cmd.op    = pmfi_pkg::OP_MUL;
      alu_cmd.start = 1'b0;
      alu_a = '0;
      alu_b = '0;

      // launch the shared unit once in every operation state
      if (st_ff != S_IDLE && st_ff != S_CLAMP && st_ff != S_DONE) begin
         alu_cmd.start = ~issued_ff;
         issued_in     = 1'b1;
         if (alu_stat.done) begin
            issued_in = 1'b0;
         end
      end

      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_thrust_cmd;
               dt_in    = req_time_step;
               hflag_in = 1'b0;
               vflag_in = 1'b0;
               if (req_mode) begin
                  vn_in = '0; ve_in = '0; vd_in = '0;
                  pn_in = '0; pe_in = '0;
                  pd_in = sat_neg(clampw(alt_ff));
                  st_in = S_DONE;
               end else begin
                  st_in = S_DRAG_N;
               end
            end
         end
         S_DRAG_N: begin
            alu_a = mag(clampw(drag_ff));
            alu_b = mag(vn_ff);
            if (alu_stat.done) begin
               dn_in = sat_neg(sat_mag(vn_ff[W-1], alu_res >> FRAC_BITS));
               st_in = S_DRAG_E;
            end
         end
         S_DRAG_E: begin
            alu_a = mag(clampw(drag_ff));
            alu_b = mag(ve_ff);
            if (alu_stat.done) begin
               de_in = sat_neg(sat_mag(ve_ff[W-1], alu_res >> FRAC_BITS));
               st_in = S_DRAG_D;
            end
         end
         S_DRAG_D: begin
            alu_a = mag(clampw(drag_ff));
            alu_b = mag(vd_ff);
            if (alu_stat.done) begin
               fz_in = sat_neg(sat_mag(vd_ff[W-1], alu_res >> FRAC_BITS));
               st_in = S_THRUST;
            end
         end
         S_THRUST: begin
            alu_a = XW'(cmd_ff);
            alu_b = mag(clampw(tmax_ff));
            if (alu_stat.done) begin
               thr_in = sat_mag(1'b0, alu_res >> pmfi_pkg::IN_FRAC);
               st_in  = S_WEIGHT;
            end
         end
         S_WEIGHT: begin
            alu_a = mag(clampw(m_eff));
            alu_b = GRAV;
            if (alu_stat.done) begin
               wgt_in = sat_mag(1'b0, alu_res >> FRAC_BITS);
               st_in  = S_BUOY;
            end
         end
         S_BUOY: begin
            alu_a = mag(wgt_ff);
            alu_b = XW'(buoyf_ff);
            if (alu_stat.done) begin
               // vertical force: weight less thrust and buoyancy, plus drag
               fz_in = sat_add(sat_add(sat_neg(sat_add(thr_ff, buoy_val)), wgt_ff), fz_ff);
               st_in = S_ACC_N;
            end
         end
         S_ACC_N: begin
            alu_cmd.op = pmfi_pkg::OP_DIV;
            alu_a = mag(dn_ff) << FRAC_BITS;
            alu_b = XW'(m_eff);
            if (alu_stat.done) begin
               tmp_in = sat_mag(dn_ff[W-1], alu_res);
               st_in  = S_DT_N;
            end
         end
         S_DT_N: begin
            alu_a = mag(tmp_ff);
            alu_b = XW'(dt_ff);
            if (alu_stat.done) begin
               vn_in = sat_add(vn_ff, sat_mag(tmp_ff[W-1], alu_res >> pmfi_pkg::IN_FRAC));
               st_in = S_ACC_E;
            end
         end
         S_ACC_E: begin
            alu_cmd.op = pmfi_pkg::OP_DIV;
            alu_a = mag(de_ff) << FRAC_BITS;
            alu_b = XW'(m_eff);
            if (alu_stat.done) begin
               tmp_in = sat_mag(de_ff[W-1], alu_res);
               st_in  = S_DT_E;
            end
         end
         S_DT_E: begin
            alu_a = mag(tmp_ff);
            alu_b = XW'(dt_ff);
            if (alu_stat.done) begin
               ve_in = sat_add(ve_ff, sat_mag(tmp_ff[W-1], alu_res >> pmfi_pkg::IN_FRAC));
               st_in = S_ACC_D;
            end
         end
         S_ACC_D: begin
            alu_cmd.op = pmfi_pkg::OP_DIV;
            alu_a = mag(fz_ff) << FRAC_BITS;
            alu_b = XW'(m_eff);
            if (alu_stat.done) begin
               tmp_in = sat_mag(fz_ff[W-1], alu_res);
               st_in  = S_DT_D;
            end
         end
         S_DT_D: begin
            alu_a = mag(tmp_ff);
            alu_b = XW'(dt_ff);
            if (alu_stat.done) begin
               vd_in = sat_add(vd_ff, sat_mag(tmp_ff[W-1], alu_res >> pmfi_pkg::IN_FRAC));
               st_in = S_SQ_N;
            end
         end
         S_SQ_N: begin
            alu_a = mag(vn_ff);
            alu_b = mag(vn_ff);
            if (alu_stat.done) begin
               sq_in = alu_res;
               st_in = S_SQ_E;
            end
         end
         S_SQ_E: begin
            alu_a = mag(ve_ff);
            alu_b = mag(ve_ff);
            if (alu_stat.done) begin
               sq_in = sq_ff + alu_res;
               st_in = S_SQ_LIM;
            end
         end
         S_SQ_LIM: begin
            alu_a = XW'(speed_ff);
            alu_b = XW'(speed_ff);
            if (alu_stat.done) begin
               st_in = (sq_ff > alu_res) ? S_SQRT : S_CLAMP;
            end
         end
         S_SQRT: begin
            alu_cmd.op = pmfi_pkg::OP_SQRT;
            alu_a = sq_ff;
            if (alu_stat.done) begin
               hs_in    = (alu_res[W-1:0] == '0) ? W'(1) : alu_res[W-1:0];
               hflag_in = 1'b1;
               st_in    = S_SCN_MUL;
            end
         end
         S_SCN_MUL: begin
            alu_a = mag(vn_ff);
            alu_b = XW'(speed_ff);
            if (alu_stat.done) begin
               sq_in = alu_res;
               st_in = S_SCN_DIV;
            end
         end
         S_SCN_DIV: begin
            alu_cmd.op = pmfi_pkg::OP_DIV;
            alu_a = sq_ff;
            alu_b = XW'(hs_ff);
            if (alu_stat.done) begin
               vn_in = sat_mag(vn_ff[W-1], alu_res);
               st_in = S_SCE_MUL;
            end
         end
         S_SCE_MUL: begin
            alu_a = mag(ve_ff);
            alu_b = XW'(speed_ff);
            if (alu_stat.done) begin
               sq_in = alu_res;
               st_in = S_SCE_DIV;
            end
         end
         S_SCE_DIV: begin
            alu_cmd.op = pmfi_pkg::OP_DIV;
            alu_a = sq_ff;
            alu_b = XW'(hs_ff);
            if (alu_stat.done) begin
               ve_in = sat_mag(ve_ff[W-1], alu_res);
               st_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            // clamp down velocity between climb and descent limits
            if (vd_ff < lo_v) begin
               vd_in    = lo_v;
               vflag_in = 1'b1;
            end else if (vd_ff > hi_v) begin
               vd_in    = hi_v;
               vflag_in = 1'b1;
            end
            st_in = S_POS_N;
         end
         S_POS_N: begin
            alu_a = mag(vn_ff);
            alu_b = XW'(dt_ff);
            if (alu_stat.done) begin
               pn_in = sat_add(pn_ff, sat_mag(vn_ff[W-1], alu_res >> pmfi_pkg::IN_FRAC));
               st_in = S_POS_E;
            end
         end
         S_POS_E: begin
            alu_a = mag(ve_ff);
            alu_b = XW'(dt_ff);
            if (alu_stat.done) begin
               pe_in = sat_add(pe_ff, sat_mag(ve_ff[W-1], alu_res >> pmfi_pkg::IN_FRAC));
               st_in = S_POS_D;
            end
         end
         S_POS_D: begin
            alu_a = mag(vd_ff);
            alu_b = XW'(dt_ff);
            if (alu_stat.done) begin
               pd_in = sat_add(pd_ff, sat_mag(vd_ff[W-1], alu_res >> pmfi_pkg::IN_FRAC));
               st_in = S_DONE;
            end
         end
         S_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_vn_in = low32(vn_ff);
               o_ve_in = low32(ve_ff);
               o_vd_in = low32(vd_ff);
               o_pn_in = low32(pn_ff);
               o_pe_in = low32(pe_ff);
               o_pd_in = low32(pd_ff);
               o_h_in  = hflag_ff;
               o_v_in  = vflag_ff;
               st_in   = S_IDLE;
            end
         end
         default: begin
            st_in     = S_IDLE;
            issued_in = 1'b0;
         end
      endcase
   end

   pmfi_alu #(
      .WORD_WIDTH (W),
      .MUL_BITS   (MB),
      .EXT_WIDTH  (XW)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_res),
      .stat   (alu_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vn_ff <= '0; ve_ff <= '0; vd_ff <= '0;
         pn_ff <= '0; pe_ff <= '0; pd_ff <= '0;
         hflag_ff <= 1'b0;
         vflag_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         vn_ff <= vn_in; ve_ff <= ve_in; vd_ff <= vd_in;
         pn_ff <= pn_in; pe_ff <= pe_in; pd_ff <= pd_in;
         hflag_ff <= hflag_in;
         vflag_ff <= vflag_in;
      end
      dn_ff <= dn_in; de_ff <= de_in; fz_ff <= fz_in;
      thr_ff <= thr_in; wgt_ff <= wgt_in; tmp_ff <= tmp_in;
      sq_ff <= sq_in; hs_ff <= hs_in;
      cmd_ff <= cmd_in; dt_ff <= dt_in;
      o_vn_ff <= o_vn_in; o_ve_ff <= o_ve_in; o_vd_ff <= o_vd_in;
      o_pn_ff <= o_pn_in; o_pe_ff <= o_pe_in; o_pd_ff <= o_pd_in;
      o_h_ff <= o_h_in; o_v_ff <= o_v_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vel_n_out     = o_vn_ff;
   assign rsp_vel_e_out     = o_ve_ff;
   assign rsp_vel_d_out     = o_vd_ff;
   assign rsp_pos_n_out     = o_pn_ff;
   assign rsp_pos_e_out     = o_pe_ff;
   assign rsp_pos_d_out     = o_pd_ff;
   assign rsp_horiz_limited = o_h_ff;
   assign rsp_vert_clamped  = o_v_ff;

   // No operation may be outstanding while a new transaction can be taken
   a_idle_no_op: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !issued_ff && !alu_stat.busy)
      else $error("arithmetic unit busy while idle");

   // The unit only finishes operations the sequencer launched
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      alu_stat.done |-> issued_ff)
      else $error("unexpected arithmetic completion");

   // A taken result leaves unless a new one is loaded
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && st_ff != S_DONE |=> !rsp_valid)
      else $error("result not released after transfer");

endmodule

/* src/pmfi_alu.sv */
module pmfi_alu #(
   parameter int WORD_WIDTH = pmfi_pkg::DEFAULT_WORD_WIDTH,
   parameter int MUL_BITS   = 32,
   parameter int EXT_WIDTH  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pmfi_pkg::alu_cmd_type  cmd,
   input  logic [EXT_WIDTH-1:0]   opa,
   input  logic [EXT_WIDTH-1:0]   opb,
   output logic [EXT_WIDTH-1:0]   result,
   output pmfi_pkg::alu_stat_type stat
);

   localparam int CW = $clog2(EXT_WIDTH + 1);

   logic [1:0]           op_ff, op_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [EXT_WIDTH-1:0] a_ff, a_in;
   logic [EXT_WIDTH-1:0] b_ff, b_in;
   logic [EXT_WIDTH-1:0] acc_ff, acc_in;
   logic [EXT_WIDTH:0]   rem_ff, rem_in;

   logic [EXT_WIDTH:0]   div_sh, div_diff;
   logic [EXT_WIDTH:0]   sq_sh, sq_trial, sq_diff;

   // One bit of quotient or root per cycle
   assign div_sh   = {rem_ff[EXT_WIDTH-1:0], a_ff[EXT_WIDTH-1]};
   assign div_diff = div_sh - {1'b0, b_ff};
   assign sq_sh    = {rem_ff[EXT_WIDTH-2:0], a_ff[EXT_WIDTH-1:EXT_WIDTH-2]};
   assign sq_trial = {acc_ff[EXT_WIDTH-2:0], 2'b01};
   assign sq_diff  = sq_sh - sq_trial;

   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         // load operands
         op_in   = cmd.op;
         busy_in = 1'b1;
         acc_in  = '0;
         rem_in  = '0;
         b_in    = opb;
         case (cmd.op)
            pmfi_pkg::OP_MUL: begin
               a_in   = opa;
               cnt_in = CW'(MUL_BITS);
            end
            pmfi_pkg::OP_DIV: begin
               a_in   = opa;
               cnt_in = CW'(EXT_WIDTH);
            end
            pmfi_pkg::OP_SQRT: begin
               a_in   = opa << (EXT_WIDTH - 2 * WORD_WIDTH);
               cnt_in = CW'(WORD_WIDTH);
            end
            default: begin
               a_in    = opa;
               cnt_in  = CW'(1);
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            pmfi_pkg::OP_MUL: begin
               // shift-add multiply
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
               a_in = a_ff << 1;
               b_in = b_ff >> 1;
            end
            pmfi_pkg::OP_DIV: begin
               // restoring divide
               a_in = a_ff << 1;
               if (!div_diff[EXT_WIDTH]) begin
                  rem_in = div_diff;
                  acc_in = {acc_ff[EXT_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in = div_sh;
                  acc_in = {acc_ff[EXT_WIDTH-2:0], 1'b0};
               end
            end
            pmfi_pkg::OP_SQRT: begin
               // digit-by-digit square root
               a_in = a_ff << 2;
               if (!sq_diff[EXT_WIDTH]) begin
                  rem_in = sq_diff;
                  acc_in = {acc_ff[EXT_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in = sq_sh;
                  acc_in = {acc_ff[EXT_WIDTH-2:0], 1'b0};
               end
            end
            default: begin
               acc_in = '0;
            end
         endcase
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= pmfi_pkg::OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign result    = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
